// ===== sv/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros
// Assertion helpers used by the checker file.
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is asserted.
`define BTTPB_ASSERT_IMP(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("%m: check failed");

// Next-cycle implication, disabled while reset is asserted.
`define BTTPB_ASSERT_NXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("%m: check failed");

`endif

// ===== sv/bttpb_pkg.sv =====
// ----------------------------------------------------------------------------
// bttpb_pkg
// Shared types and constants of the bitmap threshold page buffer.
// ----------------------------------------------------------------------------
package bttpb_pkg;

    localparam int SCREEN_COLUMNS = 84;
    localparam int SCREEN_ROWS    = 48;
    localparam int PAGE_COUNT     = (SCREEN_ROWS + 7) / 8;
    localparam int FRAME_BYTES    = SCREEN_COLUMNS * PAGE_COUNT;
    localparam int ADDR_W         = $clog2(FRAME_BYTES);
    // Wide enough for column + 1 plus the largest page offset.
    localparam int PAINT_W        = $clog2(SCREEN_COLUMNS * 8 + 129);
    localparam int QUEUE_DEPTH    = 2;

    localparam logic [3:0] LEVEL_CAP = 4'd14;

    localparam int CFG_INDEX_W = 3;
    localparam int CFG_DATA_W  = 8;

    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_X         = 3'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_Y         = 3'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_WIDTH     = 3'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_IMAGE_HEIGHT    = 3'd3;
    localparam logic [CFG_INDEX_W-1:0] CFG_LEVEL_THRESHOLD = 3'd4;

    localparam logic [1:0] OP_BEGIN = 2'd0;
    localparam logic [1:0] OP_PIXEL = 2'd1;
    localparam logic [1:0] OP_READ  = 2'd2;
    localparam logic [1:0] OP_CLEAR = 2'd3;

    localparam logic [1:0] ST_OK     = 2'd0;
    localparam logic [1:0] ST_REJECT = 2'd1;
    localparam logic [1:0] ST_IDLE   = 2'd2;

    // Work kinds handed from the front to the back.
    localparam logic [1:0] KIND_NONE  = 2'd0;
    localparam logic [1:0] KIND_PAINT = 2'd1;
    localparam logic [1:0] KIND_READ  = 2'd2;
    localparam logic [1:0] KIND_CLEAR = 2'd3;

    typedef struct packed {
        logic [1:0] opcode;
        logic [7:0] pixel_pair;
        logic [8:0] read_address;
    } bttpb_in_t;

    typedef struct packed {
        logic [7:0] buffer_byte;
        logic [1:0] status;
        logic       image_finished;
    } bttpb_out_t;

    typedef struct packed {
        logic [1:0]        kind;
        logic [ADDR_W-1:0] addr0;
        logic              en0;
        logic [ADDR_W-1:0] addr1;
        logic              en1;
        logic [2:0]        bit_sel;
        logic              val0;
        logic              val1;
        logic [1:0]        status;
        logic              finished;
    } bttpb_entry_t;

endpackage

// ===== sv/bttpb_front.sv =====
// ----------------------------------------------------------------------------
// bttpb_front
// Holds the configuration and the drawing cursor, classifies each item and
// turns it into a work entry for the back end.
// ----------------------------------------------------------------------------
module bttpb_front import bttpb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  bttpb_in_t              in_item,
    input  logic                   q_full,
    input  logic                   init_busy,
    output logic                   push,
    output bttpb_entry_t           push_entry
);

    logic [6:0] image_x_reg;
    logic [5:0] image_y_reg;
    logic [7:0] image_width_reg;
    logic [7:0] image_height_reg;
    logic [7:0] level_threshold_reg;

    logic [6:0] cursor_column_reg, cursor_column_next;
    logic [2:0] cursor_page_reg, cursor_page_next;
    logic [2:0] cursor_bit_reg, cursor_bit_next;
    logic [6:0] bytes_left_reg, bytes_left_next;
    logic [1:0] padding_left_reg, padding_left_next;
    logic [7:0] rows_left_reg, rows_left_next;
    logic       active_reg, active_next;
    logic [6:0] row_start_reg, row_start_next;
    logic [6:0] row_bytes_reg, row_bytes_next;
    logic [1:0] row_pad_reg, row_pad_next;

    logic               accept;
    logic               geom_bad;
    logic [8:0]         x_end;
    logic [8:0]         y_top;
    logic [6:0]         half_width;
    logic [3:0]         thr;
    logic [PAINT_W-1:0] col0;
    logic [PAINT_W-1:0] col1;
    logic [PAINT_W-1:0] page_base;
    logic [PAINT_W-1:0] paddr0;
    logic [PAINT_W-1:0] paddr1;
    logic [6:0]         bytes_dec;
    logic [7:0]         rows_dec;
    logic [1:0]         pad_dec;

    assign in_ready = !q_full && !init_busy;
    assign accept   = in_valid && in_ready;
    assign push     = accept;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            image_x_reg         <= '0;
            image_y_reg         <= '0;
            image_width_reg     <= '0;
            image_height_reg    <= '0;
            level_threshold_reg <= '0;
        end
        else if (cfg_write)
        begin
            unique case (cfg_index)
                CFG_IMAGE_X:         image_x_reg         <= cfg_data[6:0];
                CFG_IMAGE_Y:         image_y_reg         <= cfg_data[5:0];
                CFG_IMAGE_WIDTH:     image_width_reg     <= cfg_data;
                CFG_IMAGE_HEIGHT:    image_height_reg    <= cfg_data;
                CFG_LEVEL_THRESHOLD: level_threshold_reg <= cfg_data;
                default:
                begin
                end
            endcase
        end
    end

    assign x_end      = {2'b00, image_x_reg} + {1'b0, image_width_reg};
    assign y_top      = {3'b000, image_y_reg} + 9'd1;
    assign half_width = image_width_reg[7:1];
    assign geom_bad   = (image_height_reg == 8'd0) || image_width_reg[0]
                     || (x_end > 9'(SCREEN_COLUMNS))
                     || (y_top < {1'b0, image_height_reg})
                     || ({1'b0, image_y_reg} >= 7'(SCREEN_ROWS));

    assign thr = (level_threshold_reg > {4'd0, LEVEL_CAP}) ? LEVEL_CAP
                                                           : level_threshold_reg[3:0];

    assign col0      = PAINT_W'(cursor_column_reg);
    assign col1      = col0 + PAINT_W'(1);
    assign page_base = PAINT_W'(SCREEN_COLUMNS) * PAINT_W'(cursor_page_reg);
    assign paddr0    = col0 + page_base;
    assign paddr1    = col1 + page_base;
    assign bytes_dec = bytes_left_reg - 7'd1;
    assign rows_dec  = rows_left_reg - 8'd1;
    assign pad_dec   = padding_left_reg - 2'd1;

    always_comb
    begin
        cursor_column_next = cursor_column_reg;
        cursor_page_next   = cursor_page_reg;
        cursor_bit_next    = cursor_bit_reg;
        bytes_left_next    = bytes_left_reg;
        padding_left_next  = padding_left_reg;
        rows_left_next     = rows_left_reg;
        active_next        = active_reg;
        row_start_next     = row_start_reg;
        row_bytes_next     = row_bytes_reg;
        row_pad_next       = row_pad_reg;
        push_entry         = '0;
        push_entry.kind    = KIND_NONE;
        push_entry.status  = ST_OK;
        if (accept)
        begin
            unique case (in_item.opcode)
                OP_BEGIN:
                begin
                    if (geom_bad)
                    begin
                        active_next       = 1'b0;
                        push_entry.status = ST_REJECT;
                    end
                    else
                    begin
                        row_start_next     = image_x_reg;
                        row_bytes_next     = half_width;
                        row_pad_next       = 2'd0 - half_width[1:0];
                        cursor_column_next = image_x_reg;
                        cursor_page_next   = image_y_reg[5:3];
                        cursor_bit_next    = image_y_reg[2:0];
                        bytes_left_next    = half_width;
                        padding_left_next  = 2'd0;
                        rows_left_next     = image_height_reg;
                        active_next        = (half_width != 7'd0);
                    end
                end
                OP_PIXEL:
                begin
                    if (!active_reg)
                    begin
                        push_entry.status = ST_IDLE;
                    end
                    else if (bytes_left_reg != 7'd0)
                    begin
                        push_entry.kind    = KIND_PAINT;
                        push_entry.addr0   = ADDR_W'(paddr0);
                        push_entry.addr1   = ADDR_W'(paddr1);
                        push_entry.en0     = (col0 < PAINT_W'(SCREEN_COLUMNS))
                                          && (32'(paddr0) < FRAME_BYTES);
                        push_entry.en1     = (col1 < PAINT_W'(SCREEN_COLUMNS))
                                          && (32'(paddr1) < FRAME_BYTES);
                        push_entry.bit_sel = cursor_bit_reg;
                        push_entry.val0    = in_item.pixel_pair[7:4] > thr;
                        push_entry.val1    = in_item.pixel_pair[3:0] > thr;
                        cursor_column_next = cursor_column_reg + 7'd2;
                        bytes_left_next    = bytes_dec;
                        if (bytes_dec == 7'd0)
                        begin
                            rows_left_next = rows_dec;
                            if (rows_dec == 8'd0)
                            begin
                                push_entry.finished = 1'b1;
                                active_next         = 1'b0;
                            end
                            else
                            begin
                                // Bottom-up bitmap: the next row sits one pixel higher.
                                if (cursor_bit_reg != 3'd0)
                                begin
                                    cursor_bit_next = cursor_bit_reg - 3'd1;
                                end
                                else
                                begin
                                    cursor_bit_next  = 3'd7;
                                    cursor_page_next = cursor_page_reg - 3'd1;
                                end
                                cursor_column_next = row_start_reg;
                                padding_left_next  = row_pad_reg;
                                if (row_pad_reg == 2'd0)
                                begin
                                    bytes_left_next = row_bytes_reg;
                                end
                            end
                        end
                    end
                    else
                    begin
                        // Row padding item: counted off and dropped.
                        if (padding_left_reg != 2'd0)
                        begin
                            padding_left_next = pad_dec;
                            if (pad_dec == 2'd0)
                            begin
                                bytes_left_next = row_bytes_reg;
                            end
                        end
                        else
                        begin
                            bytes_left_next = row_bytes_reg;
                        end
                    end
                end
                OP_READ:
                begin
                    push_entry.kind  = KIND_READ;
                    push_entry.addr0 = ADDR_W'(in_item.read_address);
                    push_entry.en0   = 32'(in_item.read_address) < FRAME_BYTES;
                end
                OP_CLEAR:
                begin
                    push_entry.kind = KIND_CLEAR;
                end
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cursor_column_reg <= '0;
            cursor_page_reg   <= '0;
            cursor_bit_reg    <= '0;
            bytes_left_reg    <= '0;
            padding_left_reg  <= '0;
            rows_left_reg     <= '0;
            active_reg        <= 1'b0;
            row_start_reg     <= '0;
            row_bytes_reg     <= '0;
            row_pad_reg       <= '0;
        end
        else
        begin
            cursor_column_reg <= cursor_column_next;
            cursor_page_reg   <= cursor_page_next;
            cursor_bit_reg    <= cursor_bit_next;
            bytes_left_reg    <= bytes_left_next;
            padding_left_reg  <= padding_left_next;
            rows_left_reg     <= rows_left_next;
            active_reg        <= active_next;
            row_start_reg     <= row_start_next;
            row_bytes_reg     <= row_bytes_next;
            row_pad_reg       <= row_pad_next;
        end
    end

endmodule

// ===== sv/bttpb_queue.sv =====
// ----------------------------------------------------------------------------
// bttpb_queue
// Short FIFO of work entries between the front and the back end.
// ----------------------------------------------------------------------------
module bttpb_queue import bttpb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  logic         push,
    input  bttpb_entry_t push_entry,
    input  logic         pop,
    output bttpb_entry_t head,
    output logic         full,
    output logic         empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    bttpb_entry_t     slots_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg, count_next;

    assign full  = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign empty = (count_reg == '0);
    assign head  = slots_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(QUEUE_DEPTH - 1)) ? '0
                                                                  : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            slots_reg[wr_ptr_reg] <= push_entry;
        end
    end

endmodule

// ===== sv/bttpb_back.sv =====
// ----------------------------------------------------------------------------
// bttpb_back
// Owns the frame store: paints pixels by read-modify-write, serves reads,
// runs the clearing sweep and holds the result in the output register.
// ----------------------------------------------------------------------------
module bttpb_back import bttpb_pkg::*;
(
    input  logic         clk,
    input  logic         rst_n,
    input  bttpb_entry_t head,
    input  logic         q_empty,
    output logic         pop,
    output logic         init_busy,
    output logic         out_valid,
    input  logic         out_ready,
    output bttpb_out_t   out_item
);

    localparam logic [2:0] S_INIT = 3'd0;
    localparam logic [2:0] S_IDLE = 3'd1;
    localparam logic [2:0] S_P1   = 3'd2;
    localparam logic [2:0] S_P2   = 3'd3;
    localparam logic [2:0] S_RD   = 3'd4;
    localparam logic [2:0] S_CLR  = 3'd5;
    localparam logic [2:0] S_DONE = 3'd6;

    logic [7:0] mem [FRAME_BYTES];

    logic [2:0]        state_reg, state_next;
    logic [ADDR_W-1:0] sweep_reg, sweep_next;
    bttpb_entry_t      cur_reg;
    logic [7:0]        rdata_reg;
    logic              out_valid_reg, out_valid_next;
    bttpb_out_t        out_item_reg;

    logic              we;
    logic [ADDR_W-1:0] wa;
    logic [7:0]        wd;
    logic              re;
    logic [ADDR_W-1:0] ra;
    logic              emit;
    bttpb_out_t        emit_item;
    logic              can_emit;
    logic              sweep_last;

    function automatic logic [7:0] merge_bit(input logic [7:0] data,
                                             input logic [2:0] sel,
                                             input logic       lit);
        logic [7:0] m;
        m = 8'd1 << sel;
        return lit ? (data | m) : (data & ~m);
    endfunction

    assign can_emit   = !out_valid_reg || out_ready;
    assign sweep_last = (sweep_reg == ADDR_W'(FRAME_BYTES - 1));
    assign init_busy  = (state_reg == S_INIT);
    assign out_valid  = out_valid_reg;
    assign out_item   = out_item_reg;

    always_comb
    begin
        state_next = state_reg;
        sweep_next = sweep_reg;
        pop        = 1'b0;
        we         = 1'b0;
        wa         = cur_reg.addr0;
        wd         = 8'd0;
        re         = 1'b0;
        ra         = head.addr0;
        emit       = 1'b0;
        emit_item.buffer_byte    = 8'd0;
        emit_item.status         = cur_reg.status;
        emit_item.image_finished = cur_reg.finished;
        unique case (state_reg)
            S_INIT:
            begin
                we         = 1'b1;
                wa         = sweep_reg;
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_last)
                begin
                    sweep_next = '0;
                    state_next = S_IDLE;
                end
            end
            S_IDLE:
            begin
                if (!q_empty)
                begin
                    pop = 1'b1;
                    unique case (head.kind)
                        KIND_PAINT:
                        begin
                            re         = head.en0;
                            state_next = S_P1;
                        end
                        KIND_READ:
                        begin
                            re         = head.en0;
                            state_next = S_RD;
                        end
                        KIND_CLEAR:
                        begin
                            sweep_next = '0;
                            state_next = S_CLR;
                        end
                        default:
                        begin
                            state_next = S_DONE;
                        end
                    endcase
                end
            end
            S_P1:
            begin
                // Write back the left pixel and fetch the byte of the right one.
                we         = cur_reg.en0;
                wa         = cur_reg.addr0;
                wd         = merge_bit(rdata_reg, cur_reg.bit_sel, cur_reg.val0);
                re         = cur_reg.en1;
                ra         = cur_reg.addr1;
                state_next = S_P2;
            end
            S_P2:
            begin
                if (can_emit)
                begin
                    we         = cur_reg.en1;
                    wa         = cur_reg.addr1;
                    wd         = merge_bit(rdata_reg, cur_reg.bit_sel, cur_reg.val1);
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            S_RD:
            begin
                if (can_emit)
                begin
                    emit                  = 1'b1;
                    emit_item.buffer_byte = cur_reg.en0 ? rdata_reg : 8'd0;
                    state_next            = S_IDLE;
                end
            end
            S_CLR:
            begin
                we         = 1'b1;
                wa         = sweep_reg;
                sweep_next = sweep_reg + ADDR_W'(1);
                if (sweep_last)
                begin
                    sweep_next = '0;
                    state_next = S_DONE;
                end
            end
            S_DONE:
            begin
                if (can_emit)
                begin
                    emit       = 1'b1;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next = out_valid_reg;
        if (emit)
        begin
            out_valid_next = 1'b1;
        end
        else if (out_ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_INIT;
            sweep_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            sweep_reg     <= sweep_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop)
        begin
            cur_reg <= head;
        end
        if (emit)
        begin
            out_item_reg <= emit_item;
        end
    end

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[wa] <= wd;
        end
        if (re)
        begin
            rdata_reg <= mem[ra];
        end
    end

endmodule

// ===== sv/bitmap_threshold_to_page_buffer_core.sv =====
// ----------------------------------------------------------------------------
// bitmap_threshold_to_page_buffer_core
// Page-organized monochrome frame store fed by a 4-bit-per-pixel bitmap.
// ----------------------------------------------------------------------------
// The front end takes one item per cycle, unless the two-entry work queue is
// full or the clearing pass after reset runs, so items are accepted without
// waiting until the queue is full. The back end owns the frame store (one read
// and one write port) and sets the sustained rate, one entry at a time: a pixel
// byte is read, then written in two read-modify-write steps; a read, a begin or
// a padding or ignored byte goes straight to the result step; a clear sweeps all
// 504 bytes first. The pass after reset keeps in_ready low but takes cfg writes.
module bitmap_threshold_to_page_buffer_core import bttpb_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    input  logic                   cfg_write,
    input  logic [CFG_INDEX_W-1:0] cfg_index,
    input  logic [CFG_DATA_W-1:0]  cfg_data,
    input  logic                   in_valid,
    output logic                   in_ready,
    input  bttpb_in_t              in_item,
    output logic                   out_valid,
    input  logic                   out_ready,
    output bttpb_out_t             out_item
);

    logic         push;
    bttpb_entry_t push_entry;
    logic         pop;
    bttpb_entry_t head;
    logic         q_full;
    logic         q_empty;
    logic         init_busy;

    bttpb_front u_front (
        .clk        (clk),
        .rst_n      (rst_n),
        .cfg_write  (cfg_write),
        .cfg_index  (cfg_index),
        .cfg_data   (cfg_data),
        .in_valid   (in_valid),
        .in_ready   (in_ready),
        .in_item    (in_item),
        .q_full     (q_full),
        .init_busy  (init_busy),
        .push       (push),
        .push_entry (push_entry)
    );

    bttpb_queue u_queue (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (push),
        .push_entry (push_entry),
        .pop        (pop),
        .head       (head),
        .full       (q_full),
        .empty      (q_empty)
    );

    bttpb_back u_back (
        .clk       (clk),
        .rst_n     (rst_n),
        .head      (head),
        .q_empty   (q_empty),
        .pop       (pop),
        .init_busy (init_busy),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

endmodule

// ===== sv/bttpb_checker.sv =====
// ----------------------------------------------------------------------------
// bttpb_checker
// Port-level checks of the page buffer results, bound to the top level.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module bttpb_checker import bttpb_pkg::*;
(
    input logic       clk,
    input logic       rst_n,
    input logic       in_valid,
    input logic       in_ready,
    input bttpb_in_t  in_item,
    input logic       out_valid,
    input logic       out_ready,
    input bttpb_out_t out_item
);

    // An item that waits at the input must not change.
    `BTTPB_ASSERT_NXT(a_in_hold, clk, rst_n, in_valid && !in_ready, in_valid && $stable(in_item))

    // A result that waits must not change.
    `BTTPB_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_item))

    `BTTPB_ASSERT_IMP(a_status_code, clk, rst_n, out_valid, out_item.status == ST_OK || out_item.status == ST_REJECT || out_item.status == ST_IDLE)

    // The end of an image is only reported on a painted byte, never on a read.
    `BTTPB_ASSERT_IMP(a_finish_ok, clk, rst_n, out_valid && out_item.image_finished, out_item.status == ST_OK && out_item.buffer_byte == 8'd0)

    `BTTPB_ASSERT_IMP(a_err_no_data, clk, rst_n, out_valid && out_item.status != ST_OK, out_item.buffer_byte == 8'd0 && !out_item.image_finished)

endmodule

bind bitmap_threshold_to_page_buffer_core bttpb_checker u_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_ready  (in_ready),
    .in_item   (in_item),
    .out_valid (out_valid),
    .out_ready (out_ready),
    .out_item  (out_item)
);

// ===== dv/bitmap_threshold_to_page_buffer_core_test.sv =====
// ----------------------------------------------------------------------------
// bitmap_threshold_to_page_buffer_core_test
// Drives begin, pixel, read and clear items into the page buffer core and
// checks every response against a shadow frame store kept in the bench.
// ----------------------------------------------------------------------------
module bitmap_threshold_to_page_buffer_core_test;
    import bttpb_pkg::*;

    localparam int HALF_PERIOD     = 10;
    localparam int RESET_CYCLES    = 11;
    localparam int ITEM_GOAL       = 1650;
    localparam int SETTLE_CYCLES   = 4;
    localparam int TAIL_CYCLES     = 20;
    localparam int WATCHDOG_LIMIT  = 4000;
    localparam int PRINT_LIMIT     = 50;

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_write = 1'b0;
    logic [CFG_INDEX_W-1:0] cfg_index = '0;
    logic [CFG_DATA_W-1:0]  cfg_data = '0;
    logic                   in_valid = 1'b0;
    logic                   in_ready;
    bttpb_in_t              in_item = '0;
    logic                   out_valid;
    logic                   out_ready = 1'b0;
    bttpb_out_t             out_item;

    bitmap_threshold_to_page_buffer_core uut (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_write (cfg_write),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .in_valid  (in_valid),
        .in_ready  (in_ready),
        .in_item   (in_item),
        .out_valid (out_valid),
        .out_ready (out_ready),
        .out_item  (out_item)
    );

    // Register copies as the block holds them.
    logic [6:0] reg_x = '0;
    logic [5:0] reg_y = '0;
    logic [7:0] reg_w = '0;
    logic [7:0] reg_h = '0;
    logic [7:0] reg_thr = '0;

    // Shadow of the frame store and of the drawing cursor.
    logic [7:0] shadow_frame [FRAME_BYTES] = '{default: 8'h00};
    logic [6:0] pen_col = '0;
    logic [2:0] pen_page = '0;
    logic [2:0] pen_bit = '0;
    logic [6:0] line_left = '0;
    logic [1:0] pad_to_skip = '0;
    logic [7:0] lines_to_go = '0;
    logic       image_open = 1'b0;
    logic [6:0] line_origin = '0;
    logic [6:0] line_len = '0;
    logic [1:0] line_pad = '0;

    bttpb_in_t  items_to_send [$];
    bttpb_out_t pending_responses [$];
    bttpb_out_t awaited_response;
    int         items_built = 0;
    int         idle_mode = 0;
    int         mismatch_count = 0;
    int         quiet_cycles = 0;

    always begin
        #(HALF_PERIOD) clk = 1'b1;
        #(HALF_PERIOD) clk = 1'b0;
    end

    function automatic void shade_pixel(input int col, input logic [3:0] nib,
                                        input logic [3:0] cap);
        int addr;
        if (col >= SCREEN_COLUMNS)
            return;
        addr = col + SCREEN_COLUMNS * int'(pen_page);
        if (addr >= FRAME_BYTES)
            return;
        shadow_frame[addr][pen_bit] = (nib > cap);
    endfunction

    function automatic bttpb_out_t page_buffer_response(input bttpb_in_t it);
        bttpb_out_t r;
        logic [3:0] cap;
        r = '0;
        case (it.opcode)
            OP_BEGIN:
            begin
                if (reg_h == 0 || reg_w[0] || int'(reg_x) + int'(reg_w) > SCREEN_COLUMNS ||
                    int'(reg_y) + 1 < int'(reg_h) || int'(reg_y) >= SCREEN_ROWS)
                begin
                    image_open = 1'b0;
                    r.status = ST_REJECT;
                end
                else
                begin
                    line_origin = reg_x;
                    line_len = reg_w[7:1];
                    line_pad = 2'd0 - line_len[1:0];
                    pen_col = reg_x;
                    pen_page = 3'(reg_y >> 3);
                    pen_bit = reg_y[2:0];
                    line_left = line_len;
                    pad_to_skip = '0;
                    lines_to_go = reg_h;
                    // A zero-width image is accepted but never opens.
                    image_open = (line_len != 0);
                end
            end
            OP_PIXEL:
            begin
                if (!image_open)
                begin
                    r.status = ST_IDLE;
                end
                else if (line_left != 0)
                begin
                    cap = (reg_thr > LEVEL_CAP) ? LEVEL_CAP : reg_thr[3:0];
                    shade_pixel(int'(pen_col), it.pixel_pair[7:4], cap);
                    shade_pixel(int'(pen_col) + 1, it.pixel_pair[3:0], cap);
                    pen_col = pen_col + 7'd2;
                    line_left = line_left - 1'b1;
                    if (line_left == 0)
                    begin
                        lines_to_go = lines_to_go - 1'b1;
                        if (lines_to_go == 0)
                        begin
                            r.image_finished = 1'b1;
                            image_open = 1'b0;
                        end
                        else
                        begin
                            // Bitmap rows arrive bottom-up, so the pen climbs.
                            if (pen_bit != 0)
                            begin
                                pen_bit = pen_bit - 1'b1;
                            end
                            else
                            begin
                                pen_bit = 3'd7;
                                pen_page = pen_page - 1'b1;
                            end
                            pen_col = line_origin;
                            pad_to_skip = line_pad;
                            if (pad_to_skip == 0)
                                line_left = line_len;
                        end
                    end
                end
                else
                begin
                    if (pad_to_skip != 0)
                        pad_to_skip = pad_to_skip - 1'b1;
                    if (pad_to_skip == 0)
                        line_left = line_len;
                end
            end
            OP_READ:
            begin
                if (int'(it.read_address) < FRAME_BYTES)
                    r.buffer_byte = shadow_frame[it.read_address];
            end
            default:
            begin
                foreach (shadow_frame[i])
                    shadow_frame[i] = 8'h00;
            end
        endcase
        return r;
    endfunction

    function automatic bit take_break(input int percent);
        return $urandom_range(0, 99) < percent;
    endfunction

    task automatic report_mismatch(input string what);
        if (mismatch_count < PRINT_LIMIT)
            $display("%0t: mismatch: %s", $time, what);
        mismatch_count++;
    endtask

    // Driver: holds each item until it is taken, then predicts its response.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            in_valid <= 1'b0;
        end
        else
        begin
            if (in_valid && in_ready)
                pending_responses.push_back(page_buffer_response(in_item));
            if (!in_valid || in_ready)
            begin
                if (items_to_send.size() != 0 &&
                    !take_break(idle_mode == 0 ? 31 : idle_mode == 1 ? 68 : 0))
                begin
                    in_item <= items_to_send.pop_front();
                    in_valid <= 1'b1;
                end
                else
                begin
                    in_valid <= 1'b0;
                end
            end
        end
    end

    // Monitor: compares each response with the oldest prediction.
    always @(posedge clk)
    begin
        if (!rst_n)
        begin
            out_ready <= 1'b0;
        end
        else
        begin
            if (out_valid && out_ready)
            begin
                if (pending_responses.size() == 0)
                begin
                    report_mismatch($sformatf("response %h with no item outstanding", out_item));
                end
                else
                begin
                    awaited_response = pending_responses.pop_front();
                    if (out_item.buffer_byte !== awaited_response.buffer_byte)
                        report_mismatch($sformatf("buffer_byte got %h want %h",
                            out_item.buffer_byte, awaited_response.buffer_byte));
                    if (out_item.status !== awaited_response.status)
                        report_mismatch($sformatf("status got %h want %h",
                            out_item.status, awaited_response.status));
                    if (out_item.image_finished !== awaited_response.image_finished)
                        report_mismatch($sformatf("image_finished got %h want %h",
                            out_item.image_finished, awaited_response.image_finished));
                end
            end
            out_ready <= !take_break(idle_mode == 0 ? 68 : idle_mode == 1 ? 31 : 0);
        end
    end

    always @(posedge clk)
    begin
        if (rst_n)
        begin
            if ((in_valid && in_ready) || (out_valid && out_ready))
                quiet_cycles <= 0;
            else
                quiet_cycles <= quiet_cycles + 1;
        end
    end

    initial
    begin
        wait (quiet_cycles >= WATCHDOG_LIMIT);
        $display("bitmap_threshold_to_page_buffer_core_test NOT OK");
        $finish;
    end

    task automatic push_item(input logic [1:0] op, input int value);
        bttpb_in_t it;
        it.opcode = op;
        // Fields the operation does not use still carry random bits.
        it.pixel_pair = (op == OP_PIXEL) ? 8'(value) : 8'($urandom);
        it.read_address = (op == OP_READ) ? 9'(value) : 9'($urandom);
        items_to_send.push_back(it);
        items_built++;
    endtask

    task automatic wait_drained();
        while (items_to_send.size() != 0 || in_valid || pending_responses.size() != 0)
            @(posedge clk);
    endtask

    task automatic write_register(input logic [CFG_INDEX_W-1:0] idx, input logic [7:0] value);
        @(posedge clk);
        cfg_write <= 1'b1;
        cfg_index <= idx;
        cfg_data <= value;
        case (idx)
            CFG_IMAGE_X:      reg_x = value[6:0];
            CFG_IMAGE_Y:      reg_y = value[5:0];
            CFG_IMAGE_WIDTH:  reg_w = value;
            CFG_IMAGE_HEIGHT: reg_h = value;
            default:          reg_thr = value;
        endcase
    endtask

    task automatic apply_setting(input int x, input int y, input int w, input int h,
                                 input int thr);
        wait_drained();
        repeat (SETTLE_CYCLES) @(posedge clk);
        idle_mode = (items_built < ITEM_GOAL / 3) ? 0 : (items_built < 2 * ITEM_GOAL / 3) ? 1 : 2;
        write_register(CFG_IMAGE_X, 8'(x));
        write_register(CFG_IMAGE_Y, 8'(y));
        write_register(CFG_IMAGE_WIDTH, 8'(w));
        write_register(CFG_IMAGE_HEIGHT, 8'(h));
        write_register(CFG_LEVEL_THRESHOLD, 8'(thr));
        @(posedge clk);
        cfg_write <= 1'b0;
    endtask

    // Sends the bitmap rows with their padding, stopping early when asked.
    task automatic stream_image(input int stop_after);
        int per_row;
        int pad;
        int sent;
        per_row = int'(reg_w) / 2;
        pad = (4 - per_row % 4) % 4;
        sent = 0;
        for (int row = 0; row < int'(reg_h); row++)
        begin
            for (int b = 0; b < per_row + ((row == int'(reg_h) - 1) ? 0 : pad); b++)
            begin
                if (sent == stop_after)
                    return;
                case ($urandom_range(0, 149))
                    0:       push_item(OP_CLEAR, 0);
                    1:       push_item(OP_BEGIN, 0);
                    2, 3, 4: push_item(OP_READ, $urandom_range(0, 511));
                    default: ;
                endcase
                push_item(OP_PIXEL, $urandom_range(0, 255));
                sent++;
            end
        end
    endtask

    initial
    begin
        int x;
        int y;
        int w;
        int h;
        int thr;
        int choice;
        int stop;
        int half_max;
        int phase_no;

        repeat (RESET_CYCLES) @(posedge clk);
        rst_n <= 1'b1;

        // One-pixel-row image at the origin, with reads around the store edges.
        apply_setting(0, 0, 2, 1, 0);
        push_item(OP_PIXEL, 8'hFF);
        push_item(OP_READ, 0);
        push_item(OP_READ, FRAME_BYTES - 1);
        push_item(OP_READ, 511);
        push_item(OP_BEGIN, 0);
        push_item(OP_PIXEL, 8'hFF);
        push_item(OP_PIXEL, 8'h00);
        push_item(OP_READ, 0);
        push_item(OP_CLEAR, 0);
        push_item(OP_READ, 1);

        // Each geometry that must be rejected, then a zero-width image.
        apply_setting(82, 10, 4, 1, 0);
        push_item(OP_BEGIN, 0);
        apply_setting(0, 10, 3, 1, 0);
        push_item(OP_BEGIN, 0);
        apply_setting(0, 10, 2, 0, 0);
        push_item(OP_BEGIN, 0);
        apply_setting(0, 3, 2, 5, 0);
        push_item(OP_BEGIN, 0);
        apply_setting(0, 8'hFF, 2, 1, 0);
        push_item(OP_BEGIN, 0);
        apply_setting(8'hD3, 0, 0, 1, 0);
        push_item(OP_BEGIN, 0);
        push_item(OP_PIXEL, 8'hFF);

        // Bottom-right corner, two rows with padding, threshold far above the cap.
        apply_setting(80, 47, 4, 2, 255);
        push_item(OP_BEGIN, 0);
        push_item(OP_PIXEL, 8'hF0);
        push_item(OP_PIXEL, 8'hEF);
        push_item(OP_PIXEL, 8'hFF);
        push_item(OP_PIXEL, 8'h00);
        push_item(OP_PIXEL, 8'h0F);
        push_item(OP_PIXEL, 8'hFE);
        push_item(OP_READ, 500);
        push_item(OP_READ, 503);

        phase_no = 0;
        while (items_built < ITEM_GOAL)
        begin
            thr = ($urandom_range(0, 1) != 0) ? $urandom_range(0, 15) : $urandom_range(0, 255);
            y = $urandom_range(0, 47);
            x = $urandom_range(0, 83);
            choice = $urandom_range(0, 19);
            if (phase_no == 0)
            begin
                x = 0;
                w = SCREEN_COLUMNS;
                h = 2;
                y = $urandom_range(1, 47);
            end
            else if (phase_no == 1)
            begin
                x = $urandom_range(0, 82);
                w = 2;
                y = 47;
                h = 48;
            end
            else if (choice < 2)
            begin
                // Raw register values; nearly all of these are rejected.
                x = $urandom_range(0, 255);
                y = $urandom_range(0, 255);
                w = $urandom_range(0, 255);
                h = $urandom_range(0, 255);
            end
            else if (choice < 5)
            begin
                x = $urandom_range(0, 82);
                half_max = ((84 - x) / 2 < 4) ? (84 - x) / 2 : 4;
                w = 2 * $urandom_range(1, half_max);
                h = $urandom_range(1, y + 1);
            end
            else if (choice == 5)
            begin
                x = $urandom_range(0, 40);
                w = 2 * $urandom_range(1, (84 - x) / 2);
                h = $urandom_range(1, (y < 1) ? 1 : 2);
            end
            else
            begin
                half_max = ((84 - x) / 2 < 8) ? (84 - x) / 2 : 8;
                w = 2 * $urandom_range(0, half_max);
                h = $urandom_range(1, (y < 5) ? y + 1 : 6);
            end
            apply_setting(x, y, w, h, thr);

            // An image cut short in the last phase carries on under the new registers.
            if (image_open && $urandom_range(0, 1) != 0)
                repeat ($urandom_range(1, 20)) push_item(OP_PIXEL, $urandom_range(0, 255));
            if ($urandom_range(0, 9) == 0)
                push_item(OP_PIXEL, $urandom_range(0, 255));
            push_item(OP_BEGIN, 0);
            stop = ($urandom_range(0, 4) == 0) ? $urandom_range(0, 40) : -1;
            stream_image(stop);
            repeat ($urandom_range(2, 5))
                push_item(OP_READ, int'(reg_x) + $urandom_range(0, int'(reg_w) + 1) +
                          SCREEN_COLUMNS * $urandom_range(0, int'(reg_y) >> 3));
            if ($urandom_range(0, 5) == 0)
                push_item(OP_CLEAR, 0);
            push_item(OP_READ, $urandom_range(0, 511));
            phase_no++;
        end

        wait_drained();
        repeat (TAIL_CYCLES) @(posedge clk);
        if (mismatch_count == 0 && pending_responses.size() == 0)
            $display("bitmap_threshold_to_page_buffer_core_test OK");
        else
            $display("bitmap_threshold_to_page_buffer_core_test NOT OK");
        $finish;
    end

endmodule

// ===== files.f =====
+incdir+sv
sv/bttpb_pkg.sv
sv/bttpb_front.sv
sv/bttpb_queue.sv
sv/bttpb_back.sv
sv/bitmap_threshold_to_page_buffer_core.sv
sv/bttpb_checker.sv
dv/bitmap_threshold_to_page_buffer_core_test.sv
